@@ src/eti_pkg.sv @@
// Shared types and constants of the eased tween interpolator.
package eti_pkg;

   // Input payload and configuration index widths.
   localparam int DELTA_W     = 16;
   localparam int CSR_INDEX_W = 4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_DURATION = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_START    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_END      = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_EASING   = CSR_INDEX_W'(3);

   // Easing curve codes.
   typedef enum logic [1:0] {
      EASE_LINEAR = 2'd0,
      EASE_IN     = 2'd1,
      EASE_OUT    = 2'd2,
      EASE_IN_OUT = 2'd3
   } ease_mode_type;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CHECK    = 8'b0000_0010,
      ST_DIV      = 8'b0000_0100,
      ST_EASE_MUL = 8'b0000_1000,
      ST_EASE_FIX = 8'b0001_0000,
      ST_LERP_MUL = 8'b0010_0000,
      ST_LERP_ACC = 8'b0100_0000,
      ST_OUT      = 8'b1000_0000
   } state_type;

endpackage

@@ src/eased_tween_interpolator.sv @@
// Top level of the eased tween interpolator: sequencer, divider and shared multiplier.
//
// Each tick transfer on req_ advances the tween by req_tdata time units (req_tuser
// set restarts it first) and produces exactly one rsp_ transfer with the eased,
// interpolated value and the finished flag. One tick is handled at a time: the
// block accepts and adds, compares, runs a restoring division (one quotient bit
// per cycle), forms the easing curve in the shared multiplier and scales it back
// (linear skips the scaling), multiplies and accumulates the interpolation product
// chunk by chunk (2 chunks at the default sizes), and hands the result to the
// output register. A tick whose elapsed time already reached the duration skips
// the division; a finished tween goes straight to the output step with its held
// value. The division loop takes up most of a tick. The output register lets the
// next tick be accepted while a result still waits; that tick then holds in its
// last step until the waiting result is taken.
// Configuration writes land at once and must only be issued while the block is idle.
module eased_tween_interpolator #(
   parameter int TIME_WIDTH    = 32,
   parameter int VALUE_WIDTH   = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Tick input
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [eti_pkg::DELTA_W-1:0]            req_tdata,   // [15:0] time_step
   input  logic                                   req_tuser,   // [0] restart
   // Result output
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((VALUE_WIDTH+7)/8)*8-1:0]       rsp_tdata,   // current_value, zero pad
   output logic                                   rsp_tuser,   // [0] finished
   // Configuration write port
   input  logic                                   csr_we,
   input  logic [eti_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [((TIME_WIDTH > VALUE_WIDTH) ? TIME_WIDTH : VALUE_WIDTH)-1:0] csr_wdata
);
   import eti_pkg::*;

   localparam int TW      = TIME_WIDTH;
   localparam int VW      = VALUE_WIDTH;
   localparam int FB      = FRACTION_BITS;
   localparam int OUT_W   = ((VW + 7) / 8) * 8;
   localparam int SUM_W   = ((TW > DELTA_W) ? TW : DELTA_W) + 1;
   localparam int D       = FB + 3;                 // multiplier operand width
   localparam int PROD_W  = 2 * D;
   localparam int MAG_W   = VW + 1;
   localparam int NCHUNK  = (MAG_W + D - 1) / D;
   localparam int CHUNK_CW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int ACC_W   = (NCHUNK + 1) * D;
   localparam int DIV_CW  = $clog2(FB);

   localparam logic [TW-1:0]     TIME_MAX = {TW{1'b1}};
   localparam logic [FB:0]       ONE_T    = (FB+1)'(1) << FB;
   localparam logic [FB:0]       HALF_T   = (FB+1)'(1) << (FB - 1);
   localparam logic [D-1:0]      ONE_D    = D'(1) << FB;
   localparam logic [PROD_W-1:0] ONE_SQ   = PROD_W'(1) << (2 * FB);

   // Configuration registers
   logic [TW-1:0] duration_ff;
   logic [VW-1:0] start_ff;
   logic [VW-1:0] end_ff;
   ease_mode_type mode_ff;

   // Tween state
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic          done_ff, done_in;
   logic [VW-1:0] held_ff, held_in;

   // Sequencer and datapath
   state_type           state_ff, state_in;
   logic [TW-1:0]       rem_ff, rem_in;
   logic [FB:0]         quo_ff, quo_in;
   logic [DIV_CW-1:0]   div_cnt_ff, div_cnt_in;
   logic [FB:0]         ease_ff, ease_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CHUNK_CW-1:0] chunk_ff, chunk_in;
   // A one-cycle strobe, set in the cycle after the last accumulate, when the sum is complete.
   logic                held_pending_ff, held_pending_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]    rsp_value_ff, rsp_value_in;
   logic             rsp_fin_ff, rsp_fin_in;

   // Combinational helpers
   logic                 accept;
   logic [TW-1:0]        el_base;
   logic [SUM_W-1:0]     el_sum;
   logic [MAG_W-1:0]     diff;
   logic [TW:0]          rem_shift;
   logic [TW:0]          dur_ext;
   logic                 in_low;
   logic [D-1:0]         t_d;
   logic [D-1:0]         mul_a;
   logic [D-1:0]         mul_b;
   logic [NCHUNK*D-1:0]  mag_pad;
   logic [MAG_W-1:0]     scaled;
   logic [MAG_W-1:0]     start_ext;
   logic [MAG_W-1:0]     value_full;
   logic                 rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_fin_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Elapsed-time sum, saturated in the sequencer; restart clears the base first.
   assign el_base = req_tuser ? '0 : elapsed_ff;
   assign el_sum  = SUM_W'(el_base) + SUM_W'(req_tdata);

   // Span between end and start, kept as sign and magnitude.
   assign diff = {end_ff[VW-1], end_ff} - {start_ff[VW-1], start_ff};

   // One restoring division step.
   assign rem_shift = {rem_ff, 1'b0};
   assign dur_ext   = {1'b0, duration_ff};

   assign in_low  = (quo_ff < HALF_T);
   assign t_d     = D'(quo_ff);
   assign mag_pad = (NCHUNK*D)'(mag_ff);

   // Shared multiplier operand select; product is registered every cycle.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_EASE_MUL) begin
         mul_b = t_d;
         unique case (mode_ff)
            EASE_IN:     mul_a = t_d;
            EASE_OUT:    mul_a = (ONE_D << 1) - t_d;
            EASE_IN_OUT: mul_a = in_low ? t_d : (ONE_D << 2) - (t_d << 1);
            default:     mul_a = t_d;
         endcase
      end else if (state_ff == ST_LERP_MUL) begin
         mul_a = mag_pad[chunk_ff * D +: D];
         mul_b = D'(ease_ff);
      end
   end
   assign prod_in = mul_a * mul_b;

   // Final sum: start plus or minus the scaled span.
   assign scaled     = MAG_W'(acc_ff >> FB);
   assign start_ext  = {start_ff[VW-1], start_ff};
   assign value_full = neg_ff ? (start_ext - scaled) : (start_ext + scaled);

   assign held_pending_in = (state_ff == ST_LERP_ACC) && (chunk_ff == CHUNK_CW'(NCHUNK - 1));

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      done_in      = done_ff;
      held_in      = held_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      ease_in      = ease_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      chunk_in     = chunk_ff;
      rsp_value_in = rsp_value_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = diff[MAG_W-1];
               mag_in = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
               if (req_tuser || !done_ff) begin
                  // Advance: saturate at the all-ones maximum.
                  done_in    = 1'b0;
                  elapsed_in = (el_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TW'(el_sum);
                  state_in   = ST_CHECK;
               end else begin
                  // Finished tween: drop the delta, answer with the held value.
                  state_in = ST_OUT;
               end
            end
         end
         ST_CHECK: begin
            done_in    = (elapsed_ff >= duration_ff);
            rem_in     = elapsed_ff;
            quo_in     = '0;
            div_cnt_in = '0;
            if (elapsed_ff >= duration_ff) begin
               quo_in   = ONE_T;
               state_in = ST_EASE_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_shift >= dur_ext) begin
               rem_in = TW'(rem_shift - dur_ext);
               quo_in = {quo_ff[FB-1:0], 1'b1};
            end else begin
               rem_in = TW'(rem_shift);
               quo_in = {quo_ff[FB-1:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + DIV_CW'(1);
            if (div_cnt_ff == DIV_CW'(FB - 1)) begin
               state_in = ST_EASE_MUL;
            end
         end
         ST_EASE_MUL: begin
            acc_in   = '0;
            chunk_in = '0;
            if (mode_ff == EASE_LINEAR) begin
               ease_in  = quo_ff;
               state_in = ST_LERP_MUL;
            end else begin
               state_in = ST_EASE_FIX;
            end
         end
         ST_EASE_FIX: begin
            // Scale the curve product back to Q1.FB.
            if (mode_ff == EASE_IN_OUT && in_low) begin
               ease_in = (FB+1)'(prod_ff >> (FB - 1));
            end else if (mode_ff == EASE_IN_OUT) begin
               ease_in = (FB+1)'((prod_ff - ONE_SQ) >> FB);
            end else begin
               ease_in = (FB+1)'(prod_ff >> FB);
            end
            state_in = ST_LERP_MUL;
         end
         ST_LERP_MUL: begin
            state_in = ST_LERP_ACC;
         end
         ST_LERP_ACC: begin
            acc_in = acc_ff + (ACC_W'(prod_ff) << (chunk_ff * D));
            if (chunk_ff == CHUNK_CW'(NCHUNK - 1)) begin
               state_in = ST_OUT;
            end else begin
               chunk_in = chunk_ff + CHUNK_CW'(1);
               state_in = ST_LERP_MUL;
            end
         end
         ST_OUT: begin
            // Latch the new value on the first cycle here; a finished tween keeps its own.
            if (held_pending_ff) begin
               held_in = VW'(value_full);
            end
            // Hold here while an earlier result still waits in the output register.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_fin_in   = done_ff;
               rsp_value_in = held_pending_ff ? VW'(value_full) : held_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= '0;
         start_ff    <= '0;
         end_ff      <= '0;
         mode_ff     <= EASE_LINEAR;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_DURATION: duration_ff <= csr_wdata[TW-1:0];
            REG_START:    start_ff    <= csr_wdata[VW-1:0];
            REG_END:      end_ff      <= csr_wdata[VW-1:0];
            REG_EASING:   mode_ff     <= ease_mode_type'(csr_wdata[1:0]);
            default: begin
            end
         endcase
      end
   end

   // Control and tween state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         elapsed_ff      <= '0;
         done_ff         <= 1'b0;
         held_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         held_pending_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         elapsed_ff      <= elapsed_in;
         done_ff         <= done_in;
         held_ff         <= held_in;
         rsp_valid_ff    <= rsp_valid_in;
         held_pending_ff <= held_pending_in;
      end
   end

   // Datapath payload
   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      div_cnt_ff   <= div_cnt_in;
      ease_ff      <= ease_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      chunk_ff     <= chunk_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

endmodule

@@ sim/tb_eased_tween_interpolator.sv @@
// Self-checking testbench for the eased tween interpolator: directed ticks and random tweens.
module tb_eased_tween_interpolator;
   import eti_pkg::*;

   // Quiet cycles (no transfer on either side) before the run is declared hung.
   localparam int WATCHDOG_LIMIT   = 2000;
   // Length of the long receiver hold-off that backs the block up.
   localparam int SINK_HOLD_CYCLES = 300;
   // Settle time before a register write; covers the slowest tick of the block.
   localparam int SETTLE_CYCLES    = 40;
   // Random tween setups and ticks per setup.
   localparam int RANDOM_SETUPS    = 24;
   localparam int TICKS_PER_SETUP  = 50;

   localparam logic [31:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [31:0] value;
      logic        finished;
   } tween_result_type;

   // Tracks the tween state from accepted ticks and holds the results still owed.
   class tween_tracker;
      localparam int FRAC = 16;
      localparam longint unsigned ONE = 64'd1 << FRAC;

      logic [31:0]      duration;
      logic [31:0]      start_val;
      logic [31:0]      end_val;
      ease_mode_type    mode;
      logic [31:0]      elapsed;
      logic [31:0]      held;
      bit               done;
      tween_result_type pending_values[$];
      int               errors;
      int               checked;

      function new();
         duration  = '0;
         start_val = '0;
         end_val   = '0;
         mode      = EASE_LINEAR;
         elapsed   = '0;
         held      = '0;
         done      = 1'b0;
         errors    = 0;
         checked   = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_DURATION: duration  = val;
            REG_START:    start_val = val;
            REG_END:      end_val   = val;
            REG_EASING:   mode      = ease_mode_type'(val[1:0]);
            default: ;
         endcase
      endfunction

      // Progress in Q1.16, pinned to one once the duration is reached.
      function longint unsigned progress();
         if (duration == 0 || elapsed >= duration) return ONE;
         return ({32'd0, elapsed} << FRAC) / {32'd0, duration};
      endfunction

      function longint unsigned eased(longint unsigned t);
         case (mode)
            EASE_IN:  return (t * t) >> FRAC;
            EASE_OUT: return (t * (2 * ONE - t)) >> FRAC;
            EASE_IN_OUT: begin
               if (t < ONE / 2) return (2 * t * t) >> FRAC;
               return ((4 * ONE - 2 * t) * t - ONE * ONE) >> FRAC;
            end
            default:  return t;
         endcase
      endfunction

      // Move from start toward end by the eased factor, truncating toward start.
      function logic [31:0] blend(longint unsigned e);
         longint          a;
         longint          b;
         longint          diff;
         longint unsigned mag;
         longint unsigned scaled;
         bit              neg;
         a      = $signed(start_val);
         b      = $signed(end_val);
         diff   = b - a;
         neg    = diff < 0;
         mag    = neg ? -diff : diff;
         scaled = (mag >> FRAC) * e + (((mag & (ONE - 1)) * e) >> FRAC);
         if (neg) return 32'(a - longint'(scaled));
         return 32'(a + longint'(scaled));
      endfunction

      function void note_tick(logic [DELTA_W-1:0] delta, logic restart);
         logic [32:0] sum;
         if (restart) begin
            elapsed = '0;
            done    = 1'b0;
         end
         if (!done) begin
            sum     = {1'b0, elapsed} + delta;
            elapsed = sum[32] ? '1 : sum[31:0];
            held    = blend(eased(progress()));
            done    = elapsed >= duration;
         end
         pending_values.push_back('{held, done});
      endfunction

      task report(string what);
         errors++;
         $display("tween mismatch at result %0d: %s", checked, what);
      endtask

      task check_value(logic [31:0] value, logic finished);
         tween_result_type want;
         if (pending_values.size() == 0) begin
            report($sformatf("unexpected value %h finished %b", value, finished));
            return;
         end
         want = pending_values.pop_front();
         checked++;
         if (value !== want.value)
            report($sformatf("value %h, want %h", value, want.value));
         if (finished !== want.finished)
            report($sformatf("finished %b, want %b", finished, want.finished));
      endtask
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [DELTA_W-1:0]      req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [31:0]             rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [31:0]             csr_wdata  = '0;

   // Idling controls shared between the stimulus and the receiver.
   bit src_idle_en   = 1'b0;
   bit sink_idle_en  = 1'b0;
   bit sink_hold_req = 1'b0;

   tween_tracker tracker;
   int           setups;

   eased_tween_interpolator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] time_step
      .req_tuser  (req_tuser),    // [0] restart
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [31:0] current_value
      .rsp_tuser  (rsp_tuser),    // [0] finished
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Monitor both channels at the edge: a tick transfer queues its expected result,
   // a result transfer is checked against the oldest one.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) tracker.note_tick(req_tdata, req_tuser);
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_value(rsp_tdata, rsp_tuser);
   end

   // Receiver: random stall bursts, or one long hold-off on request, otherwise ready.
   initial begin : sink
      int hold_count;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_req) begin
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < SINK_HOLD_CYCLES; hold_count++)
               @(posedge clock);
            sink_hold_req = 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb_eased_tween_interpolator: done, errors");
      $finish;
   end

   // Offer one tick, after an optional sender gap, and hold it until the transfer.
   // Leave tvalid high on return so back-to-back ticks keep it asserted between them.
   task automatic send_tick(input logic [DELTA_W-1:0] delta, input logic restart);
      int gap;
      gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= delta;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop tvalid, drain every owed result, then let the block settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (tracker.pending_values.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back, plus one write to an unused index.
   task automatic load_tween(input logic [31:0] dur, input logic [31:0] from_val,
                             input logic [31:0] to_val, input ease_mode_type curve);
      logic [CSR_INDEX_W-1:0] idx [5];
      logic [31:0]            val [5];
      idx = '{REG_DURATION, REG_START, REG_END, REG_EASING,
              CSR_INDEX_W'($urandom_range(4, 15))};
      val = '{dur, from_val, to_val, {30'($urandom), curve}, 32'($urandom)};
      wait_idle();
      foreach (idx[i]) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         tracker.write_reg(idx[i], val[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      setups++;
   endtask

   function automatic logic [31:0] pick_duration();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 32'd1;
         2:       return '1;
         3:       return 32'($urandom);
         4, 5:    return 32'($urandom_range(2, 5000));
         default: return 32'($urandom_range(5000, 1000000));
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return 32'($urandom);
         default: return 32'($urandom_range(0, 2000)) - 32'd1000;
      endcase
   endfunction

   // Deltas scaled to the duration so most tweens run through to the end.
   function automatic logic [DELTA_W-1:0] pick_delta(logic [31:0] dur);
      logic [31:0] step;
      step = dur / 12;
      if (step == 0) step = 1;
      if (step > 32'd32767) step = 32'd32767;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return DELTA_W'($urandom);
         default: return DELTA_W'($urandom_range(0, 2 * step));
      endcase
   endfunction

   initial begin : stimulus
      int  setup;
      int  k;
      logic restart;
      tracker = new();
      setups  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero duration finishes on the first tick, then holds.
      send_tick(16'd0, 1'b0);
      send_tick(16'd100, 1'b0);

      // Full-range linear sweep, then a tick on a finished tween.
      load_tween(32'd1000, VALUE_MIN, VALUE_MAX, EASE_LINEAR);
      send_tick(16'd0, 1'b1);
      send_tick(16'd500, 1'b0);
      send_tick(16'hFFFF, 1'b0);
      send_tick(16'd7, 1'b0);

      // New settings while finished must not show until a restart.
      load_tween(32'd3, 32'd12345, VALUE_MIN, EASE_IN);
      send_tick(16'd1, 1'b0);
      send_tick(16'd1, 1'b1);
      send_tick(16'd1, 1'b0);
      send_tick(16'd1, 1'b0);

      load_tween(32'd65536, -32'sd7, 32'd1000000, EASE_OUT);
      send_tick(16'd0, 1'b1);
      send_tick(16'd16384, 1'b0);
      send_tick(16'd32768, 1'b0);
      send_tick(16'd16384, 1'b0);

      // Ease-in-out across its midpoint, where the curve switches branches.
      load_tween(32'd65536, 32'd1000000, -32'sd1000000, EASE_IN_OUT);
      send_tick(16'd0, 1'b1);
      send_tick(16'd32767, 1'b0);
      send_tick(16'd1, 1'b0);
      send_tick(16'd1, 1'b0);
      send_tick(16'd32767, 1'b0);

      // Longest duration, restart on every tick.
      load_tween('1, '0, VALUE_MAX, EASE_IN_OUT);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'hFFFF, 1'b1);

      // Zero duration with restart: finished on the same tick.
      load_tween('0, '1, 32'd1, EASE_OUT);
      send_tick(16'd0, 1'b1);
      send_tick(16'hFFFF, 1'b1);

      // Random tweens; idling off in the last setups.
      for (setup = 0; setup < RANDOM_SETUPS; setup++) begin
         load_tween(pick_duration(), pick_value(), pick_value(),
                    ease_mode_type'($urandom_range(0, 3)));
         src_idle_en  = (setup < RANDOM_SETUPS - 4) && $urandom_range(0, 3) != 0;
         sink_idle_en = (setup < RANDOM_SETUPS - 4) && $urandom_range(0, 3) != 0;
         // Hold the receiver off while ticks keep coming, so the input backs up.
         if (setup == 4 || setup == 13) begin
            src_idle_en   = 1'b0;
            sink_hold_req = 1'b1;
         end
         for (k = 0; k < TICKS_PER_SETUP; k++) begin
            restart = $urandom_range(0, 11) == 0 ||
                      (tracker.done && $urandom_range(0, 1) == 0);
            send_tick(pick_delta(tracker.duration), restart);
         end
      end

      wait_idle();
      $display("checked %0d results over %0d tween setups: all easing curves, restarts,",
               tracker.checked, setups);
      $display("zero and full-range durations, extreme values, held finished tweens, stalls");
      if (tracker.errors == 0 && tracker.pending_values.size() == 0) begin
         $display("tb_eased_tween_interpolator: done, clean");
      end else begin
         $display("tb_eased_tween_interpolator: done, errors");
      end
      $finish;
   end

endmodule
